// ===== rtl/core/ethernet_rx_address_filter_deframer_defines.svh =====
// Assertion macros for the receive address filter and deframer.
// No dependencies; taken in by files that carry concurrent assertions.
`ifndef ETHERNET_RX_ADDRESS_FILTER_DEFRAMER_DEFINES_SVH
`define ETHERNET_RX_ADDRESS_FILTER_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ERAFD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("erafd: invariant violated");

// cons must hold in the cycle after ante
`define ERAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("erafd: sequence violated");

`else

`define ERAFD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ERAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/erafd_pkg.sv =====
// Shared constants and types of the receive address filter and deframer.
// No dependencies.
package erafd_pkg;

	localparam int MAX_FRAME_BYTES = 1518;
	localparam int POS_W           = 11;
	localparam int ADDR_BYTES      = 6;
	localparam int HDR_BYTES       = 14;
	localparam int TYPE_HI_POS     = 12;
	localparam int TYPE_LO_POS     = 13;

	localparam int BYTE_W  = 8;
	localparam int TYPE_W  = 16;
	localparam int MAC_W   = 48;
	localparam logic [BYTE_W-1:0] BCAST_BYTE = 8'hFF;

	// short queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// register interface
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic REG_STATION_ADDRESS = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [TYPE_W-1:0] ether_type;
		logic              payload_last;
	} payload_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             own_match;
		logic             broadcast_match;
	} front_status_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic               full;
		logic               empty;
	} fifo_status_t;

endpackage

// ===== rtl/core/erafd_frame_if.sv =====
// Receive byte channel: valid/ready handshake carrying one frame byte.
// Depends on erafd_pkg.
interface erafd_frame_if;
	logic                         valid;
	logic                         ready;
	logic [erafd_pkg::BYTE_W-1:0] frame_byte;
	logic                         frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/erafd_payload_if.sv =====
// Payload channel: valid/ready handshake carrying one tagged payload byte.
// Depends on erafd_pkg.
interface erafd_payload_if;
	logic                         valid;
	logic                         ready;
	logic [erafd_pkg::BYTE_W-1:0] payload_byte;
	logic [erafd_pkg::TYPE_W-1:0] ether_type;
	logic                         payload_last;

	modport source (output valid, output payload_byte, output ether_type,
		output payload_last, input ready);
	modport sink   (input valid, input payload_byte, input ether_type,
		input payload_last, output ready);
endinterface

// ===== rtl/core/ethernet_rx_address_filter_deframer.sv =====
// Ethernet receive destination filter and deframer.
// Usage:
//  - frame_in takes one received byte per transfer, frame_end set on the
//    last byte. Header bytes 0..5 are checked against the station address
//    and broadcast; 12..13 give the ethertype; from byte 14 on, bytes of
//    matching frames leave on payload_out tagged with the ethertype.
//  - Frames with no match, or shorter than the header, produce nothing.
//    Bytes past 1518 are ignored; byte 1517 is then marked last.
//  - Throughput: one byte per cycle, sustained, in and out, while payload_out is ready.
//  - A payload byte reaches payload_out through a queue write, then an
//    output register load.
//  - A stalled receiver fills the four-entry queue plus the output register;
//    frame_in.ready then drops and recovers the cycle after a payload_out transfer.
//  - Header bytes take no queue space, but ready still drops on a full queue.
//  - APB register 0 (byte address 0, 64-bit data): station address in
//    bits 47..0, first byte on the wire in bits 47..40. Write only when idle.
//  - Reset (arst_n low): start of frame, both matches set, queue empty,
//    ethertype and station address cleared.
// Depends on erafd_pkg, both channel interfaces, the front, queue and
// output stage modules, and the assertion macro header.
`include "ethernet_rx_address_filter_deframer_defines.svh"

module ethernet_rx_address_filter_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	erafd_frame_if.sink                    frame_in,
	erafd_payload_if.source                payload_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [erafd_pkg::APB_AW-1:0]   paddr,
	input  logic [erafd_pkg::APB_DW-1:0]   pwdata,
	output logic [erafd_pkg::APB_DW-1:0]   prdata,
	output logic                           pready
);

	// register file
	logic [erafd_pkg::MAC_W-1:0]  station_q;
	logic                         reg_write;
	logic                         reg_index;

	// front to queue
	logic                         push;
	erafd_pkg::payload_t          entry;
	erafd_pkg::front_status_t     front_status;

	// queue to back
	erafd_pkg::payload_t          head;
	erafd_pkg::fifo_status_t      fifo_status;
	logic                         pop;

	// 8-byte register stride: bit 3 selects the register
	assign reg_index = paddr[3];
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
		end else if (reg_write && reg_index == erafd_pkg::REG_STATION_ADDRESS) begin
			station_q <= pwdata[erafd_pkg::MAC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_index == erafd_pkg::REG_STATION_ADDRESS) begin
			prdata = erafd_pkg::APB_DW'(station_q);
		end
	end

	// front end: position tracking, address filter, ethertype capture
	erafd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.station  (station_q),
		.frame_in (frame_in),
		.space    (!fifo_status.full),
		.push     (push),
		.entry    (entry),
		.status   (front_status)
	);

	// decouples the line-rate input from receiver stalls
	erafd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.status    (fifo_status)
	);

	// registered output onto the payload channel
	erafd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!fifo_status.empty),
		.pop         (pop),
		.payload_out (payload_out)
	);

	// queue never overfills
	`ERAFD_ASSERT_ALWAYS(a_fifo_bound, clk, arst_n,
		fifo_status.count <= erafd_pkg::FIFO_CW'(erafd_pkg::FIFO_DEPTH))

	// input back-pressure only comes from a full queue
	`ERAFD_ASSERT_ALWAYS(a_ready_space, clk, arst_n,
		frame_in.ready == !fifo_status.full)

	// a frame end always restarts header parsing with both matches armed
	`ERAFD_ASSERT_NEXT(a_frame_restart, clk, arst_n,
		frame_in.valid && frame_in.ready && frame_in.frame_end,
		front_status.pos == '0 && front_status.own_match && front_status.broadcast_match)

	// a queue entry always leaves once the output register is free
	`ERAFD_ASSERT_NEXT(a_drain, clk, arst_n,
		!fifo_status.empty && (!payload_out.valid || payload_out.ready),
		payload_out.valid)

endmodule

// ===== rtl/core/erafd_front.sv =====
// Front end: takes frame bytes, tracks header position, filters on address.
// Depends on erafd_pkg and erafd_frame_if.
module erafd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [erafd_pkg::MAC_W-1:0]     station,
	erafd_frame_if.sink                     frame_in,
	input  logic                            space,
	output logic                            push,
	output erafd_pkg::payload_t             entry,
	output erafd_pkg::front_status_t        status
);

	logic [erafd_pkg::POS_W-1:0]  pos_q;
	logic                         own_q;
	logic                         bcast_q;
	logic [erafd_pkg::TYPE_W-1:0] type_q;

	logic                         accept;
	logic                         in_range;
	logic                         is_addr;
	logic                         is_last;
	logic [erafd_pkg::BYTE_W-1:0] own_byte;

	assign frame_in.ready = space;
	assign accept   = frame_in.valid && space;
	assign in_range = pos_q < erafd_pkg::POS_W'(erafd_pkg::MAX_FRAME_BYTES);
	assign is_addr  = pos_q < erafd_pkg::POS_W'(erafd_pkg::ADDR_BYTES);
	assign is_last  = frame_in.frame_end
		|| pos_q == erafd_pkg::POS_W'(erafd_pkg::MAX_FRAME_BYTES - 1);

	// first byte on the wire is the top of the address
	always_comb begin
		unique case (pos_q[2:0])
			3'd0:    own_byte = station[47:40];
			3'd1:    own_byte = station[39:32];
			3'd2:    own_byte = station[31:24];
			3'd3:    own_byte = station[23:16];
			3'd4:    own_byte = station[15:8];
			3'd5:    own_byte = station[7:0];
			default: own_byte = '0;
		endcase
	end

	assign push = accept && in_range && (own_q || bcast_q)
		&& pos_q >= erafd_pkg::POS_W'(erafd_pkg::HDR_BYTES);
	assign entry.payload_byte = frame_in.frame_byte;
	assign entry.ether_type   = type_q;
	assign entry.payload_last = is_last;

	assign status.pos             = pos_q;
	assign status.own_match       = own_q;
	assign status.broadcast_match = bcast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			own_q   <= 1'b1;
			bcast_q <= 1'b1;
			type_q  <= '0;
		end else if (accept) begin
			if (in_range && pos_q == erafd_pkg::POS_W'(erafd_pkg::TYPE_HI_POS)) begin
				type_q[15:8] <= frame_in.frame_byte;
			end
			if (in_range && pos_q == erafd_pkg::POS_W'(erafd_pkg::TYPE_LO_POS)) begin
				type_q[7:0] <= frame_in.frame_byte;
			end
			if (frame_in.frame_end) begin
				pos_q   <= '0;
				own_q   <= 1'b1;
				bcast_q <= 1'b1;
			end else begin
				// saturates at the length limit; extra bytes are dropped
				if (in_range) begin
					pos_q <= pos_q + 1'b1;
				end
				if (is_addr) begin
					own_q   <= own_q && (frame_in.frame_byte == own_byte);
					bcast_q <= bcast_q && (frame_in.frame_byte == erafd_pkg::BCAST_BYTE);
				end
			end
		end
	end

endmodule

// ===== rtl/core/erafd_fifo.sv =====
// Short queue of payload entries between the front end and the output stage.
// Depends on erafd_pkg.
module erafd_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  erafd_pkg::payload_t       push_data,
	input  logic                      pop,
	output erafd_pkg::payload_t       head,
	output erafd_pkg::fifo_status_t   status
);

	erafd_pkg::payload_t              mem_q [erafd_pkg::FIFO_DEPTH];
	logic [erafd_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [erafd_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [erafd_pkg::FIFO_CW-1:0]    count_q;
	logic                             do_push;
	logic                             do_pop;

	assign status.count = count_q;
	assign status.full  = count_q == erafd_pkg::FIFO_CW'(erafd_pkg::FIFO_DEPTH);
	assign status.empty = count_q == '0;
	assign head         = mem_q[rd_ptr_q];

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/erafd_back.sv =====
// Output stage: registers the queue head onto the payload channel.
// Depends on erafd_pkg and erafd_payload_if.
module erafd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  erafd_pkg::payload_t       head,
	input  logic                      head_valid,
	output logic                      pop,
	erafd_payload_if.source           payload_out
);

	logic                 out_valid_q;
	erafd_pkg::payload_t  out_q;

	// refill whenever the register is empty or being drained this cycle
	assign pop = head_valid && (!out_valid_q || payload_out.ready);

	assign payload_out.valid        = out_valid_q;
	assign payload_out.payload_byte = out_q.payload_byte;
	assign payload_out.ether_type   = out_q.ether_type;
	assign payload_out.payload_last = out_q.payload_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (payload_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

endmodule
